### src/tcw_pkg.sv
// Shared types and constants of the text console writer.
// Depends on nothing; every other file of the block imports it.
package tcw_pkg;

    localparam logic [1:0] REQ_PUT       = 2'd0;
    localparam logic [1:0] REQ_BACKSPACE = 2'd1;
    localparam logic [1:0] REQ_CLEAR     = 2'd2;
    localparam logic [1:0] REQ_READ      = 2'd3;

    localparam logic [7:0] CH_BLANK   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam int         TAB_STEP   = 4;

    localparam logic [7:0] ATTR_RESET = 8'd7;

    // Register index decoded from paddr[2].
    localparam logic REG_DEFAULT_ATTR = 1'b0;

    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] chr;
    } cell_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } cmd_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] read_char;
        logic [7:0] read_attr;
    } rsp_t;

endpackage

### src/text_console_writer_unit.sv
// Top level of the text console writer: configuration port, sequencer,
// screen store and output register. Depends on tcw_pkg, tcw_ctrl, tcw_screen_mem.
//
// Usage:
//   Requests enter on cmd (cmd_valid / cmd_stall); each gives exactly one
//   response on rsp (rsp_valid / rsp_stall) carrying the cursor after the
//   request and, for a cell read, the cell's character and attribute.
//   Put, backspace and clear responses pass the result register and the output
//   register; cell reads first pass the store's registered read data. Puts and
//   backspaces are taken one per cycle unless a result waits on a stalled output.
//   A read holds off the next request until its data is back. A clear, or a put
//   that runs past the last row, blanks the store one cell per cycle, so the next
//   request waits for the whole sweep. After reset the same sweep fills the
//   store with blanks of attribute 7 while cmd_stall is high; the
//   default_attribute register can be written through the APB port meanwhile.
//   While rsp_stall holds a response, one more response can be completed
//   internally; after that cmd_stall rises until the output drains.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_t        cmd,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [7:0]    attr_reg;
    logic          out_valid_reg;
    rsp_t          out_data_reg;

    logic          res_valid;
    logic          res_ready;
    rsp_t          res_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    cell_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    cell_t         mem_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DEFAULT_ATTR) ? {24'd0, attr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_DEFAULT_ATTR)
        begin
            attr_reg <= pwdata[7:0];
        end
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .AW      (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .default_attr (attr_reg),
        .res_ready    (res_ready),
        .res_valid    (res_valid),
        .res_data     (res_data),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    tcw_screen_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The output register takes a new response whenever it is empty or being drained.
    assign res_ready = !out_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= res_data;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

### src/tcw_screen_mem.sv
// Screen cell store: one write port and one read port with registered read data.
// Depends on tcw_pkg for the cell type.
module tcw_screen_mem
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  cell_t         wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output cell_t         rdata
);

    cell_t mem_reg [DEPTH];
    cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/tcw_ctrl.sv
// Request sequencer: cursor update, store writes, read issue and the blanking sweep.
// Depends on tcw_pkg; drives the ports of tcw_screen_mem.
module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int CELLS   = COLUMNS * ROWS,
    parameter int AW      = $clog2(CELLS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  cmd_t          cmd,
    input  logic [7:0]    default_attr,
    input  logic          res_ready,
    output logic          res_valid,
    output rsp_t          res_data,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output cell_t         mem_wdata,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    input  cell_t         mem_rdata
);

    localparam int CW = $clog2(COLUMNS + TAB_STEP);
    localparam int RW = $clog2(ROWS + 1);

    typedef enum logic [1:0] {ST_SWEEP, ST_IDLE, ST_READ} state_t;

    state_t          st_reg;
    logic [AW-1:0]   sweep_addr_reg;
    logic [7:0]      blank_attr_reg;
    logic [CW-1:0]   col_reg;
    logic [RW-1:0]   row_reg;
    logic            res_valid_reg;
    rsp_t            res_data_reg;
    logic            oob_reg;

    logic            accept;
    logic            oob;
    logic [AW-1:0]   cur_idx;
    logic [CW-1:0]   col_adv;
    logic [RW-1:0]   row_adv;
    logic            put_writes;
    logic            wrap_rows;
    logic [CW-1:0]   col_fin;
    logic [RW-1:0]   row_fin;
    logic            sweep_go;
    logic            res_load;

    assign cmd_stall = (st_reg != ST_IDLE) || (res_valid_reg && !res_ready);
    assign accept    = cmd_valid && !cmd_stall;
    assign oob       = 32'(cmd.cell_address) >= 32'(CELLS);
    assign cur_idx   = AW'(AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg));

    // A response is produced by every accepted request except a read, which
    // completes in the cycle after its acceptance, once the store's data is back.
    assign res_load  = (st_reg == ST_READ) || (accept && cmd.req_type != REQ_READ);

    // Cursor motion of a put: newline, tab or a printed character, then column wrap.
    always_comb
    begin
        col_adv    = col_reg;
        row_adv    = row_reg;
        put_writes = 1'b0;
        if (cmd.char_code == CH_NEWLINE)
        begin
            col_adv = '0;
            row_adv = row_reg + 1'b1;
        end
        else if (cmd.char_code == CH_TAB)
        begin
            col_adv = col_reg + CW'(TAB_STEP);
        end
        else
        begin
            col_adv    = col_reg + 1'b1;
            put_writes = 1'b1;
        end
        if (col_adv >= CW'(COLUMNS))
        begin
            col_adv = '0;
            row_adv = row_adv + 1'b1;
        end
        wrap_rows = row_adv >= RW'(ROWS);
    end

    always_comb
    begin
        col_fin  = col_reg;
        row_fin  = row_reg;
        sweep_go = 1'b0;
        unique case (cmd.req_type)
            REQ_PUT:
            begin
                if (wrap_rows)
                begin
                    col_fin  = '0;
                    row_fin  = '0;
                    sweep_go = 1'b1;
                end
                else
                begin
                    col_fin = col_adv;
                    row_fin = row_adv;
                end
            end
            REQ_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    col_fin = col_reg - 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                col_fin  = '0;
                row_fin  = '0;
                sweep_go = 1'b1;
            end
            REQ_READ:
            begin
                col_fin = col_reg;
            end
        endcase
    end

    // The sweep owns the write port; requests are held off while it runs.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_idx;
        mem_wdata = '{attr: default_attr, chr: cmd.char_code};
        if (st_reg == ST_SWEEP)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = '{attr: blank_attr_reg, chr: CH_BLANK};
        end
        else if (accept && cmd.req_type == REQ_PUT)
        begin
            mem_we = put_writes;
        end
        else if (accept && cmd.req_type == REQ_BACKSPACE)
        begin
            mem_we    = col_reg != '0;
            mem_waddr = cur_idx - 1'b1;
            mem_wdata = '{attr: default_attr, chr: CH_BLANK};
        end
    end

    assign mem_re    = accept && (cmd.req_type == REQ_READ) && !oob;
    assign mem_raddr = AW'(cmd.cell_address);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_SWEEP;
            sweep_addr_reg <= '0;
            blank_attr_reg <= ATTR_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            res_valid_reg  <= 1'b0;
            res_data_reg   <= '0;
            oob_reg        <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_SWEEP:
                begin
                    if (sweep_addr_reg == AW'(CELLS - 1))
                    begin
                        sweep_addr_reg <= '0;
                        st_reg         <= ST_IDLE;
                    end
                    else
                    begin
                        sweep_addr_reg <= sweep_addr_reg + 1'b1;
                    end
                end
                ST_READ:
                begin
                    res_data_reg.cursor_col <= 7'(col_reg);
                    res_data_reg.cursor_row <= 5'(row_reg);
                    res_data_reg.read_char  <= oob_reg ? 8'd0 : mem_rdata.chr;
                    res_data_reg.read_attr  <= oob_reg ? 8'd0 : mem_rdata.attr;
                    st_reg                  <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        col_reg <= col_fin;
                        row_reg <= row_fin;
                        if (cmd.req_type == REQ_READ)
                        begin
                            oob_reg <= oob;
                            st_reg  <= ST_READ;
                        end
                        else
                        begin
                            res_data_reg.cursor_col <= 7'(col_fin);
                            res_data_reg.cursor_row <= 5'(row_fin);
                            res_data_reg.read_char  <= 8'd0;
                            res_data_reg.read_attr  <= 8'd0;
                        end
                        if (sweep_go)
                        begin
                            blank_attr_reg <= default_attr;
                            st_reg         <= ST_SWEEP;
                        end
                    end
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < CW'(COLUMNS) && row_reg < RW'(ROWS))
        else $error("cursor left the screen");

    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.req_type == REQ_CLEAR |=>
            st_reg == ST_SWEEP && res_valid_reg && col_reg == '0 && row_reg == '0)
        else $error("clear did not home the cursor and start the sweep");

    a_sweep_steps: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_SWEEP && $past(st_reg == ST_SWEEP) && $past(rst_n) |->
            sweep_addr_reg == $past(sweep_addr_reg) + 1'b1)
        else $error("sweep skipped or repeated a cell");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready |=> res_valid_reg && $stable(res_data_reg))
        else $error("pending result lost or changed");

endmodule
